// ===== rtl/pcl_pkg.sv =====
package pcl_pkg;

    localparam int SLOT_W = 8;
    localparam int PAT_W  = 8;

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_APPEND  = 3'd1,
        OP_INSERT  = 3'd2,
        OP_REMOVE  = 3'd3,
        OP_SET_LEN = 3'd4,
        OP_RST_POS = 3'd5,
        OP_ADVANCE = 3'd6,
        OP_READ    = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_APPEND,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    // Command broadcast along the row of cells; each cell compares its own
    // index against slot and count.
    typedef struct packed {
        cell_op_t          op;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] count;
        logic [PAT_W-1:0]  pat;
    } cell_cmd_t;

    typedef enum logic {
        ST_RUN,
        ST_MOD
    } ctrl_state_t;

endpackage

// ===== rtl/pcl_cell.sv =====
module pcl_cell #(
    parameter int IDX = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pcl_pkg::cell_cmd_t     cmd,
    input  logic [pcl_pkg::PAT_W-1:0] left_data,
    input  logic [pcl_pkg::PAT_W-1:0] right_data,
    output logic [pcl_pkg::PAT_W-1:0] data
);
    import pcl_pkg::*;

    localparam logic [SLOT_W:0] MY_IDX  = (SLOT_W+1)'(IDX);
    localparam logic [SLOT_W:0] MY_IDX1 = (SLOT_W+1)'(IDX + 1);

    logic [PAT_W-1:0] data_reg;
    logic [PAT_W-1:0] data_next;
    logic [SLOT_W:0]  slot_x;
    logic [SLOT_W:0]  count_x;

    assign slot_x  = {1'b0, cmd.slot};
    assign count_x = {1'b0, cmd.count};

    always_comb begin
        data_next = data_reg;
        case (cmd.op)
            CELL_CLEAR: begin
                data_next = '0;
            end
            CELL_APPEND: begin
                if (MY_IDX == count_x) begin
                    data_next = cmd.pat;
                end
            end
            CELL_INSERT: begin
                if (MY_IDX == slot_x) begin
                    data_next = cmd.pat;
                end else if (MY_IDX > slot_x && MY_IDX <= count_x) begin
                    data_next = left_data;
                end
            end
            CELL_REMOVE: begin
                if (MY_IDX >= slot_x && MY_IDX1 < count_x) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

// ===== rtl/pcl_mod.sv =====
module pcl_mod #(
    parameter int WIDTH = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] remainder
);
    localparam int STEP_W = $clog2(WIDTH);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [WIDTH-1:0]  dvd_reg;
    logic [WIDTH-1:0]  dvd_next;
    logic [WIDTH-1:0]  div_reg;
    logic [WIDTH-1:0]  div_next;
    logic [WIDTH-1:0]  rem_reg;
    logic [WIDTH-1:0]  rem_next;
    logic [WIDTH:0]    trial;
    logic [WIDTH:0]    diff;

    // Restoring remainder, one dividend bit per cycle.
    assign trial = {rem_reg, dvd_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = WIDTH'(diff);
            end else begin
                rem_next = WIDTH'(trial);
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/pattern_chain_list_core.sv =====
// Channel | Direction | Ports                      | Contents
// --------+-----------+----------------------------+---------------------------------------
// s_      | in        | s_tvalid s_tready s_tdata  | one list operation per item; the
//         |           | s_tuser                    | operation code in s_tuser
// m_      | out       | m_tvalid m_tready m_tdata  | one result per item: flag, count,
//         |           |                            | position, current and read entries
//
// An item is applied to the row of cells, the count and the position in the cycle it is
// accepted, and its result is formed from the updated state once the output register is
// free, so a new item can be accepted every cycle while results are taken. The one
// exception is an advance whose position is not below count - 1: the wrap goes through
// the bit-serial remainder unit, and no item is accepted until it is done.
// Reset (aresetn low, synchronous) clears every cell at once, sets the count to one and
// the position to zero, and drops any pending result.
// A stalled result is held in the output register; one further item may be applied
// while it waits, and the input then stalls until the result is taken.
module pattern_chain_list_core #(
    parameter int LIST_CAPACITY = 64,
    parameter int PATTERN_COUNT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] slot_position, [15:8] pattern_number,
                                   // [23:16] new_count
    input  logic [2:0]  s_tuser,   // [2:0] op
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] accepted, [7:1] list_count, [13:8] play_position,
                                   // [21:14] current_pattern, [29:22] read_value,
                                   // [31:30] zero
);
    import pcl_pkg::*;

    // The count has to reach the capacity itself; the position stays below it.
    localparam int CNT_W = $clog2(LIST_CAPACITY + 1);
    localparam int POS_W = $clog2(LIST_CAPACITY);

    // ---------------------------------------------------------------------------------
    // Input fields
    // ---------------------------------------------------------------------------------
    op_t               in_op;
    logic [SLOT_W-1:0] in_slot;
    logic [PAT_W-1:0]  in_pat;
    logic [SLOT_W-1:0] in_req;

    assign in_op   = op_t'(s_tuser);
    assign in_slot = s_tdata[7:0];
    assign in_pat  = s_tdata[15:8];
    assign in_req  = s_tdata[23:16];

    // ---------------------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------------------
    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [POS_W-1:0]  position_reg;
    logic [POS_W-1:0]  position_next;

    // The item whose result is still to be formed.
    logic              pend_reg;
    logic              pend_next;
    op_t               pend_op_reg;
    op_t               pend_op_next;
    logic [SLOT_W-1:0] pend_slot_reg;
    logic [SLOT_W-1:0] pend_slot_next;
    logic              pend_ok_reg;
    logic              pend_ok_next;

    // Output register
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [31:0]       m_data_reg;
    logic [31:0]       m_data_next;

    // ---------------------------------------------------------------------------------
    // Row of cells
    // ---------------------------------------------------------------------------------
    cell_cmd_t         cmd;
    logic [PAT_W-1:0]  cell_data [LIST_CAPACITY];

    for (genvar g = 0; g < LIST_CAPACITY; g++) begin : g_cell
        logic [PAT_W-1:0] left_d;
        logic [PAT_W-1:0] right_d;

        if (g == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[g-1];
        end

        if (g == LIST_CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[g+1];
        end

        pcl_cell #(
            .IDX (g)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g])
        );
    end

    // ---------------------------------------------------------------------------------
    // Remainder unit for the advance wrap
    // ---------------------------------------------------------------------------------
    logic              mod_start;
    logic              mod_done;
    logic [CNT_W-1:0]  mod_rem;
    logic [CNT_W-1:0]  pos_inc;

    // The position is below the capacity, so one more still fits the count's width.
    assign pos_inc = CNT_W'(position_reg) + 1'b1;

    pcl_mod #(
        .WIDTH (CNT_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (pos_inc),
        .divisor   (count_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // ---------------------------------------------------------------------------------
    // Checks on the incoming item
    // ---------------------------------------------------------------------------------
    logic              full;
    logic              pat_ok;
    logic              ins_slot_ok;
    logic              rem_slot_ok;
    logic [CNT_W-1:0]  count_dec;
    logic [CNT_W-1:0]  req_clamped;
    logic              accept;
    logic              out_load;

    assign full        = count_reg >= CNT_W'(LIST_CAPACITY);
    assign pat_ok      = {1'b0, in_pat} < 9'(PATTERN_COUNT);
    assign ins_slot_ok = {1'b0, in_slot} <= 9'(count_reg);
    assign rem_slot_ok = {1'b0, in_slot} < 9'(count_reg);
    assign count_dec   = count_reg - 1'b1;
    assign req_clamped = ({1'b0, in_req} > 9'(LIST_CAPACITY)) ?
                         CNT_W'(LIST_CAPACITY) : CNT_W'(in_req);

    // A pending result moves into the output register once that register is free.
    assign out_load = pend_reg && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // ---------------------------------------------------------------------------------
    // Control: next state, cell command and handshake
    // ---------------------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        position_next  = position_reg;
        pend_next      = pend_reg;
        pend_op_next   = pend_op_reg;
        pend_slot_next = pend_slot_reg;
        pend_ok_next   = pend_ok_reg;
        mod_start      = 1'b0;
        cmd.op         = CELL_HOLD;
        cmd.slot       = in_slot;
        cmd.count      = SLOT_W'(count_reg);
        cmd.pat        = in_pat;
        s_tready       = 1'b0;

        if (out_load) begin
            pend_next = 1'b0;
        end

        unique case (state_reg)
            ST_RUN: begin
                s_tready = !pend_reg || out_load;
                if (accept) begin
                    pend_next      = 1'b1;
                    pend_op_next   = in_op;
                    pend_slot_next = in_slot;
                    pend_ok_next   = 1'b1;
                    unique case (in_op)
                        OP_CLEAR: begin
                            cmd.op        = CELL_CLEAR;
                            count_next    = '0;
                            position_next = '0;
                        end
                        OP_APPEND: begin
                            if (!full && pat_ok) begin
                                cmd.op     = CELL_APPEND;
                                count_next = count_reg + 1'b1;
                            end else begin
                                pend_ok_next = 1'b0;
                            end
                        end
                        OP_INSERT: begin
                            if (!full && pat_ok && ins_slot_ok) begin
                                cmd.op     = CELL_INSERT;
                                count_next = count_reg + 1'b1;
                            end else begin
                                pend_ok_next = 1'b0;
                            end
                        end
                        OP_REMOVE: begin
                            if (rem_slot_ok) begin
                                cmd.op     = CELL_REMOVE;
                                count_next = count_dec;
                                // Pull the position back below the shorter list.
                                if (count_dec != '0 &&
                                    CNT_W'(position_reg) >= count_dec) begin
                                    position_next = POS_W'(count_dec - 1'b1);
                                end
                            end else begin
                                pend_ok_next = 1'b0;
                            end
                        end
                        OP_SET_LEN: begin
                            count_next = req_clamped;
                        end
                        OP_RST_POS: begin
                            position_next = '0;
                        end
                        OP_ADVANCE: begin
                            if (count_reg != '0) begin
                                if (pos_inc < count_reg) begin
                                    position_next = POS_W'(pos_inc);
                                end else begin
                                    // Wrap, possibly from a stale position far past
                                    // the count: take the true remainder.
                                    mod_start  = 1'b1;
                                    pend_next  = 1'b0;
                                    state_next = ST_MOD;
                                end
                            end
                        end
                        OP_READ: begin
                            cmd.op = CELL_HOLD;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    position_next = POS_W'(mod_rem);
                    pend_next     = 1'b1;
                    state_next    = ST_RUN;
                end
            end
        endcase
    end

    // ---------------------------------------------------------------------------------
    // Result forming from the state left by the pending item
    // ---------------------------------------------------------------------------------
    logic [PAT_W-1:0]  cur_pat;
    logic [PAT_W-1:0]  rd_val;
    logic              rd_in_range;

    assign rd_in_range = {1'b0, pend_slot_reg} < 9'(count_reg);
    assign cur_pat     = (count_reg == '0) ? '0 : cell_data[position_reg];
    assign rd_val      = (pend_op_reg == OP_READ && rd_in_range) ?
                         cell_data[POS_W'(pend_slot_reg)] : '0;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {2'b00, rd_val, cur_pat, 6'(position_reg), 7'(count_reg),
                            pend_ok_reg};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            count_reg    <= CNT_W'(1);
            position_reg <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            position_reg <= position_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_op_reg   <= pend_op_next;
        pend_slot_reg <= pend_slot_next;
        pend_ok_reg   <= pend_ok_next;
        m_data_reg    <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/pcl_checker.sv =====
module pcl_checker #(
    parameter int LIST_CAPACITY = 64
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A result that is not taken stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset leaves no result on the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An empty list shows no current pattern and reads as zero.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7:1] == 7'd0 && LIST_CAPACITY < 128 |->
            m_tdata[21:14] == 8'd0 && m_tdata[29:22] == 8'd0)
        else $error("empty list reports an entry");

    // With a result stalled, at most one further item gets in before the input stalls.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tvalid && !m_tready ##1 !m_tready |-> !s_tready)
        else $error("input ready with a result and an item waiting");

    // Padding bits of a result stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:30] == 2'b00)
        else $error("result padding bits set");

endmodule

bind pattern_chain_list_core pcl_checker #(
    .LIST_CAPACITY (LIST_CAPACITY)
) u_pcl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
